// File: hw/rtl/ipv4dq_pkg.sv
`default_nettype none

package ipv4dq_pkg;

   localparam int MAX_CHARS  = 15;
   localparam int MAX_DIGITS = 3;

   localparam int CHAR_COUNT_WIDTH  = 5;
   localparam int DOT_COUNT_WIDTH   = 3;
   localparam int DIGIT_COUNT_WIDTH = 3;
   localparam int PART_VALUE_WIDTH  = 10;
   localparam int PRODUCT_WIDTH     = 14;

   localparam logic [CHAR_COUNT_WIDTH-1:0] CHAR_COUNT_SAT =
      CHAR_COUNT_WIDTH'(MAX_CHARS + 1);
   localparam logic [CHAR_COUNT_WIDTH-1:0] CHAR_COUNT_LIMIT =
      CHAR_COUNT_WIDTH'(MAX_CHARS);
   localparam logic [DIGIT_COUNT_WIDTH-1:0] DIGIT_COUNT_SAT =
      DIGIT_COUNT_WIDTH'(MAX_DIGITS + 1);
   localparam logic [DIGIT_COUNT_WIDTH-1:0] DIGIT_COUNT_LIMIT =
      DIGIT_COUNT_WIDTH'(MAX_DIGITS);
   localparam logic [DOT_COUNT_WIDTH-1:0] DOT_COUNT_SAT      = 3'd4;
   localparam logic [DOT_COUNT_WIDTH-1:0] DOT_COUNT_EXPECTED = 3'd3;
   localparam logic [PART_VALUE_WIDTH-1:0] PART_VALUE_SAT    = 10'd1023;
   localparam logic [PART_VALUE_WIDTH-1:0] OCTET_MAX         = 10'd255;

   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [7:0] DIGIT_LOW  = 8'h30;
   localparam logic [7:0] DIGIT_HIGH = 8'h39;

   localparam logic [7:0] CLASS_A_MAX = 8'd127;
   localparam logic [7:0] CLASS_B_MAX = 8'd191;
   localparam logic [7:0] CLASS_C_MAX = 8'd223;

   localparam logic [3:0] STATUS_OK          = 4'd0;
   localparam logic [3:0] STATUS_TOO_LONG    = 4'd1;
   localparam logic [3:0] STATUS_BAD_CHAR    = 4'd2;
   localparam logic [3:0] STATUS_DOTS_NOT_3  = 4'd3;
   localparam logic [3:0] STATUS_DOUBLE_DOT  = 4'd4;
   localparam logic [3:0] STATUS_TRAIL_DOT   = 4'd5;
   localparam logic [3:0] STATUS_PART_LONG   = 4'd6;
   localparam logic [3:0] STATUS_OVER_RANGE  = 4'd7;
   localparam logic [3:0] STATUS_FIRST_ZERO  = 4'd8;

   localparam logic [1:0] CLASS_A     = 2'd0;
   localparam logic [1:0] CLASS_B     = 2'd1;
   localparam logic [1:0] CLASS_C     = 2'd2;
   localparam logic [1:0] CLASS_OTHER = 2'd3;

   typedef struct packed {
      logic [7:0] character;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic [3:0] status;
      logic [1:0] address_class;
      logic [7:0] octet_first;
      logic [7:0] octet_second;
      logic [7:0] octet_third;
      logic [7:0] octet_fourth;
   } rsp_word_type;

   typedef struct packed {
      logic bad_char;
      logic double_dot;
      logic long_part;
      logic over_range;
   } error_flags_type;

   typedef struct packed {
      logic [CHAR_COUNT_WIDTH-1:0]  char_count;
      logic [DOT_COUNT_WIDTH-1:0]   dot_count;
      logic                         previous_was_dot;
      logic [DIGIT_COUNT_WIDTH-1:0] part_digit_count;
      logic [PART_VALUE_WIDTH-1:0]  part_value;
      logic [3:0][7:0]              octet_store;
      error_flags_type              error_flags;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_CLEAR = '0;

endpackage

`default_nettype wire

// File: hw/rtl/ipv4_dotted_quad_checker_unit.sv
// Result words are registered in the output word register. Throughput: one character
// word per cycle unless stalled; the parse state updates in a single pass.
// A stalled result word stalls the input only when another final character is ready.
// Reset is synchronous and active high; it empties both word registers and clears
// the parse state, so the next character starts a new address.
`default_nettype none

module ipv4_dotted_quad_checker_unit
   import ipv4dq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_word_type    in_word_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_word_type    out_word_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_word_type    step_word;
   logic            fire;
   logic            req_take;

   ipv4dq_step u_step (
      .state_cur  (state_ff),
      .req_word   (in_word_ff),
      .state_next (state_in),
      .rsp_word   (step_word)
   );

   assign fire      = in_valid_ff && (!in_word_ff.is_last || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      if (!req_stall) begin
         in_valid_in = req_valid;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (fire && in_word_ff.is_last) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PARSE_STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (fire && in_word_ff.is_last) begin
         out_word_ff <= step_word;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ipv4dq_step.sv
`default_nettype none

module ipv4dq_step
   import ipv4dq_pkg::*;
(
   input  wire parse_state_type state_cur,
   input  wire req_word_type    req_word,
   output parse_state_type      state_next,
   output rsp_word_type         rsp_word
);

   logic                         is_dot;
   logic                         is_digit;
   logic [PRODUCT_WIDTH-1:0]     product;
   logic [PART_VALUE_WIDTH-1:0]  digit_value;
   logic [DIGIT_COUNT_WIDTH-1:0] digit_count;
   logic [PART_VALUE_WIDTH-1:0]  close_value;
   logic [DIGIT_COUNT_WIDTH-1:0] close_count;
   logic                         close_part;
   parse_state_type              upd;
   logic [7:0]                   first;
   logic [3:0]                   status;
   logic [1:0]                   addr_class;

   assign is_dot   = (req_word.character == DOT_CHAR);
   assign is_digit = (req_word.character >= DIGIT_LOW) && (req_word.character <= DIGIT_HIGH);

   assign product = PRODUCT_WIDTH'(state_cur.part_value) * PRODUCT_WIDTH'(10)
                    + PRODUCT_WIDTH'(req_word.character[3:0]);

   always_comb begin
      if (product > PRODUCT_WIDTH'(PART_VALUE_SAT)) begin
         digit_value = PART_VALUE_SAT;
      end else begin
         digit_value = product[PART_VALUE_WIDTH-1:0];
      end
      if (state_cur.part_digit_count < DIGIT_COUNT_SAT) begin
         digit_count = state_cur.part_digit_count + 1'b1;
      end else begin
         digit_count = state_cur.part_digit_count;
      end
   end

   always_comb begin
      upd = state_cur;
      if (state_cur.char_count < CHAR_COUNT_SAT) begin
         upd.char_count = state_cur.char_count + 1'b1;
      end
      upd.previous_was_dot = is_dot;
      if (is_digit) begin
         upd.part_digit_count = digit_count;
         upd.part_value       = digit_value;
      end else if (!is_dot) begin
         upd.error_flags.bad_char = 1'b1;
      end
      if (is_dot && state_cur.previous_was_dot) begin
         upd.error_flags.double_dot = 1'b1;
      end

      // A dot closes the part built so far; the final character closes the
      // part that includes it.
      close_part  = is_dot || req_word.is_last;
      close_value = upd.part_value;
      close_count = upd.part_digit_count;
      if (close_part) begin
         if (close_count > DIGIT_COUNT_LIMIT) begin
            upd.error_flags.long_part = 1'b1;
         end else if (close_value > OCTET_MAX) begin
            upd.error_flags.over_range = 1'b1;
         end
         if (state_cur.dot_count < DOT_COUNT_SAT) begin
            upd.octet_store[state_cur.dot_count[1:0]] = close_value[7:0];
         end
         upd.part_digit_count = '0;
         upd.part_value       = '0;
      end
      if (is_dot && (state_cur.dot_count < DOT_COUNT_SAT)) begin
         upd.dot_count = state_cur.dot_count + 1'b1;
      end
   end

   assign first = upd.octet_store[0];

   always_comb begin
      priority if (upd.char_count > CHAR_COUNT_LIMIT) begin
         status = STATUS_TOO_LONG;
      end else if (upd.error_flags.bad_char) begin
         status = STATUS_BAD_CHAR;
      end else if (upd.dot_count != DOT_COUNT_EXPECTED) begin
         status = STATUS_DOTS_NOT_3;
      end else if (upd.error_flags.double_dot) begin
         status = STATUS_DOUBLE_DOT;
      end else if (is_dot) begin
         status = STATUS_TRAIL_DOT;
      end else if (upd.error_flags.long_part) begin
         status = STATUS_PART_LONG;
      end else if (upd.error_flags.over_range) begin
         status = STATUS_OVER_RANGE;
      end else if (first == 8'd0) begin
         status = STATUS_FIRST_ZERO;
      end else begin
         status = STATUS_OK;
      end

      priority if (first <= CLASS_A_MAX) begin
         addr_class = CLASS_A;
      end else if (first <= CLASS_B_MAX) begin
         addr_class = CLASS_B;
      end else if (first <= CLASS_C_MAX) begin
         addr_class = CLASS_C;
      end else begin
         addr_class = CLASS_OTHER;
      end
   end

   always_comb begin
      rsp_word.status = status;
      if (status == STATUS_OK) begin
         rsp_word.address_class = addr_class;
         rsp_word.octet_first   = upd.octet_store[0];
         rsp_word.octet_second  = upd.octet_store[1];
         rsp_word.octet_third   = upd.octet_store[2];
         rsp_word.octet_fourth  = upd.octet_store[3];
      end else begin
         rsp_word.address_class = CLASS_OTHER;
         rsp_word.octet_first   = 8'd0;
         rsp_word.octet_second  = 8'd0;
         rsp_word.octet_third   = 8'd0;
         rsp_word.octet_fourth  = 8'd0;
      end

      if (req_word.is_last) begin
         state_next = PARSE_STATE_CLEAR;
      end else begin
         state_next = upd;
      end
   end

endmodule

`default_nettype wire
